// File: design/lbfr_pkg.sv
// Shared types, codes and helper functions for the LIN block frame receiver.
`timescale 1ns / 1ps

package lbfr_pkg;

   localparam int FRAMES_PER_BLOCK_DEF     = 8;
   localparam int DATA_BYTES_PER_FRAME_DEF = 8;

   localparam int ID_W    = 6;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

   typedef enum logic [0:0] {
      OP_BREAK = 1'b0,
      OP_BYTE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_DROP,
      PH_SYNC,
      PH_PID,
      PH_DATA,
      PH_CSUM
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_OK   = 2'd1,
      ST_HDR  = 2'd2,
      ST_CSUM = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BERR_OK   = 2'd0,
      BERR_HDR  = 2'd1,
      BERR_CSUM = 2'd2
   } berr_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic               byte_valid;
      logic [BYTE_W-1:0]  byte_value;
      logic [INDEX_W-1:0] byte_index;
      status_type         frame_status;
      logic               block_done;
      berr_type           block_error;
   } rsp_item_type;

   // LIN protected ID parity bits {P1, P0}
   function automatic logic [1:0] lin_parity(input logic [ID_W-1:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0};
   endfunction

   // 8-bit add with end-around carry
   function automatic logic [BYTE_W-1:0] add_carry(input logic [BYTE_W-1:0] s,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0] t;
      t = {1'b0, s} + {1'b0, b};
      return t[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, t[BYTE_W]};
   endfunction

endpackage

// File: design/lbfr_in_stage.sv
// Input register stage: holds one accepted item until the frame engine takes it.
`timescale 1ns / 1ps

module lbfr_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lbfr_pkg::req_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output lbfr_pkg::req_item_type item
);
   import lbfr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: design/lbfr_frame_fsm.sv
// Frame engine: header checks, data byte indexing, checksum and block bookkeeping.
`timescale 1ns / 1ps

module lbfr_frame_fsm #(
   parameter int FRAMES_PER_BLOCK     = lbfr_pkg::FRAMES_PER_BLOCK_DEF,
   parameter int DATA_BYTES_PER_FRAME = lbfr_pkg::DATA_BYTES_PER_FRAME_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [lbfr_pkg::ID_W-1:0]   csr_wdata,
   input  logic                        step,
   input  lbfr_pkg::req_item_type      item,
   output logic                        rslt_present,
   output lbfr_pkg::rsp_item_type      rslt
);
   import lbfr_pkg::*;

   localparam int SLOT_W = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;
   localparam int BIF_W  = (DATA_BYTES_PER_FRAME > 1) ? $clog2(DATA_BYTES_PER_FRAME) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAMES_PER_BLOCK - 1);
   localparam logic [BIF_W-1:0]  BIF_LAST  = BIF_W'(DATA_BYTES_PER_FRAME - 1);

   logic [ID_W-1:0]    accepted_id_ff;
   phase_type          phase_ff, phase_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [BIF_W-1:0]   bif_ff, bif_in;
   logic [INDEX_W-1:0] widx_ff, widx_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   berr_type           sticky_ff, sticky_in;

   logic [BYTE_W-1:0]  b;
   logic               slot_end;
   status_type         end_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_id_ff <= '0;
      end else if (csr_we) begin
         accepted_id_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         slot_ff   <= '0;
         bif_ff    <= '0;
         widx_ff   <= '0;
         sum_ff    <= '0;
         sticky_ff <= BERR_OK;
      end else begin
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         bif_ff    <= bif_in;
         widx_ff   <= widx_in;
         sum_ff    <= sum_in;
         sticky_ff <= sticky_in;
      end
   end

   assign b = item.rx_byte;

   always_comb begin
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      bif_in       = bif_ff;
      widx_in      = widx_ff;
      sum_in       = sum_ff;
      sticky_in    = sticky_ff;
      slot_end     = 1'b0;
      end_status   = ST_NONE;
      rslt_present = 1'b0;
      rslt         = '0;

      if (step) begin
         if (item.op == OP_BREAK) begin
            // break counts only while waiting for a header
            if (phase_ff == PH_WAIT) begin
               phase_in = PH_DROP;
            end
         end else begin
            unique case (phase_ff)
               PH_WAIT: begin
               end
               PH_DROP: begin
                  phase_in = PH_SYNC;
               end
               PH_SYNC: begin
                  if (b != SYNC_BYTE) begin
                     slot_end   = 1'b1;
                     end_status = ST_HDR;
                  end else begin
                     phase_in = PH_PID;
                  end
               end
               PH_PID: begin
                  if (b[ID_W-1:0] != accepted_id_ff ||
                      b[BYTE_W-1:ID_W] != lin_parity(b[ID_W-1:0])) begin
                     slot_end   = 1'b1;
                     end_status = ST_HDR;
                  end else begin
                     sum_in   = b;
                     bif_in   = '0;
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  sum_in            = add_carry(sum_ff, b);
                  rslt_present      = 1'b1;
                  rslt.byte_valid   = 1'b1;
                  rslt.byte_value   = b;
                  rslt.byte_index   = widx_ff;
                  widx_in           = widx_ff + INDEX_W'(1);
                  bif_in            = bif_ff + BIF_W'(1);
                  if (bif_ff == BIF_LAST) begin
                     phase_in = PH_CSUM;
                  end
               end
               PH_CSUM: begin
                  slot_end   = 1'b1;
                  end_status = (b != ~sum_ff) ? ST_CSUM : ST_OK;
               end
               default: begin
               end
            endcase
         end
      end

      if (slot_end) begin
         if (end_status == ST_HDR) begin
            sticky_in = BERR_HDR;
         end else if (end_status == ST_CSUM) begin
            sticky_in = BERR_CSUM;
         end
         phase_in          = PH_WAIT;
         bif_in            = '0;
         sum_in            = '0;
         rslt_present      = 1'b1;
         rslt.frame_status = end_status;
         if (slot_ff == SLOT_LAST) begin
            rslt.block_done  = 1'b1;
            rslt.block_error = sticky_in;
            slot_in          = '0;
            widx_in          = '0;
            sticky_in        = BERR_OK;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

endmodule

// File: design/lbfr_out_stage.sv
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module lbfr_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  lbfr_pkg::rsp_item_type rslt,
   output logic                   out_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output lbfr_pkg::rsp_item_type rsp_item
);
   import lbfr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rslt;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = data_ff;

endmodule

// File: design/lin_block_frame_receiver.sv
// LIN slave block receiver (enhanced checksum): top level and stream ports.
// An item's result goes from the input register through the frame engine into the result register.
// Throughput: one item per cycle; the input and result registers stall only on rsp_tready.
// Items that cause no result (breaks, dropped, good sync and good PID bytes) still take a slot
// in the input register until they advance.
// Reset: synchronous, active high; clears accepted_id, frame state and both valid flags.
`timescale 1ns / 1ps

module lin_block_frame_receiver #(
   parameter int FRAMES_PER_BLOCK     = lbfr_pkg::FRAMES_PER_BLOCK_DEF,
   parameter int DATA_BYTES_PER_FRAME = lbfr_pkg::DATA_BYTES_PER_FRAME_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [lbfr_pkg::ID_W-1:0] csr_wdata,  // accepted_id
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // rx_byte[7:0]
   input  logic                      req_tuser,  // op[0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // byte_value[7:0], byte_index[13:8], frame_status[15:14], block_error[17:16], zero pad
   output logic [23:0]               rsp_tdata,
   output logic                      rsp_tuser,  // byte_valid[0]
   output logic                      rsp_tlast   // block_done
);
   import lbfr_pkg::*;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         advance;
   logic         out_free;
   logic         rslt_present;
   rsp_item_type rslt;
   rsp_item_type rsp_item;

   assign req_item.op      = op_type'(req_tuser);
   assign req_item.rx_byte = req_tdata;

   assign advance = item_valid && out_free;

   lbfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lbfr_frame_fsm #(
      .FRAMES_PER_BLOCK     (FRAMES_PER_BLOCK),
      .DATA_BYTES_PER_FRAME (DATA_BYTES_PER_FRAME)
   ) u_frame_fsm (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .step         (advance),
      .item         (item),
      .rslt_present (rslt_present),
      .rslt         (rslt)
   );

   lbfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && rslt_present),
      .rslt       (rslt),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {6'd0, rsp_item.block_error, rsp_item.frame_status,
                       rsp_item.byte_index, rsp_item.byte_value};
   assign rsp_tuser = rsp_item.byte_valid;
   assign rsp_tlast = rsp_item.block_done;

`ifndef SYNTHESIS
   // a new item may only enter a full input register when the held one moves on
   a_in_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && item_valid |-> advance)
      else $error("input register overwritten before its item advanced");

   // block end always comes with a frame status and never with a data byte
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[15:14] != ST_NONE && !rsp_tuser)
      else $error("block end without frame status");

   // data byte results carry no frame or block status
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:14] == ST_NONE && rsp_tdata[17:16] == BERR_OK)
      else $error("data byte result carries status");
`endif

endmodule
